[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define ASSERT_OFF to drop
// every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/pfde_pkg.sv]
// ----------------------------------------------------------------------------
// pfde_pkg
// Types and constants of the postfix digit evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfde_pkg;

    localparam int DATA_W = 32;
    localparam int ITER_W = 5;
    localparam logic [ITER_W-1:0] ITER_LAST = 5'd31;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_UNDERFLOW = 3'd1,
        STS_OVERFLOW  = 3'd2,
        STS_DIVZERO   = 3'd3,
        STS_BADSYM    = 3'd4,
        STS_EMPTY     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DFIX,
        ST_EMIT
    } state_t;

    // Magnitude of a two's complement word
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

[hdl/postfix_digit_evaluator_top.sv]
// Sequence: a digit passes ST_DECODE; '+'/'-' add ST_EXEC; '*' then ST_MUL,
//   '/' ST_DIV, ST_DFIX; a last character loads the result register in ST_EMIT.
// Throughput: one request at a time; the worst case is set by the 32-step
//   shared add/subtract unit in divide (and multiply).
// Reset: rst_n clears the sequencer, stack count, sticky error and result
//   valid; stack memory contents are not cleared (only written entries read).
// ----------------------------------------------------------------------------
// postfix_digit_evaluator_top
// Evaluates postfix expressions of single digits and + - * / one character
// per request, with a value stack in memory and one iterative arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module postfix_digit_evaluator_top #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         symbol,
    input  wire logic               last,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      value,
    output logic [2:0]              status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = pfde_pkg::DATA_W;

    // Control state
    pfde_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    pfde_pkg::status_t err_reg, err_next;
    logic              out_valid_reg;

    // Datapath registers
    logic [7:0]                 sym_reg;
    logic                       last_reg;
    logic [DW-1:0]              tos_reg, tos_next;
    logic [DW-1:0]              opa_reg, opa_next;
    logic [DW-1:0]              opb_reg, opb_next;
    logic [DW-1:0]              acc_reg, acc_next;
    logic [pfde_pkg::ITER_W-1:0] itr_reg, itr_next;
    logic                       neg_reg, neg_next;
    logic [DW-1:0]              rd_reg;
    logic [DW-1:0]              value_reg;
    pfde_pkg::status_t          status_reg;

    // Stack memory, holds entries below the top of stack
    logic [DW-1:0] stack_mem [STACK_DEPTH];
    logic          mem_we;
    logic [CW-1:0] cnt_m1, cnt_m2;
    logic [AW-1:0] wr_idx, rd_idx;

    // Shared add/subtract unit
    logic [DW:0] add_a, add_b, add_sum;
    logic        add_sub;

    logic       accept;
    logic       out_load;
    logic       is_digit, is_op;
    logic [DW:0] rem_shift;
    logic       last_next_step;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != pfde_pkg::ST_IDLE);

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);
    assign wr_idx = cnt_m1[AW-1:0];
    assign rd_idx = cnt_m2[AW-1:0];

    assign is_digit = (sym_reg >= pfde_pkg::CH_ZERO) && (sym_reg <= pfde_pkg::CH_NINE);
    assign is_op    = (sym_reg == pfde_pkg::CH_PLUS) || (sym_reg == pfde_pkg::CH_MINUS) ||
                      (sym_reg == pfde_pkg::CH_STAR) || (sym_reg == pfde_pkg::CH_SLASH);

    assign rem_shift = {acc_reg, opa_reg[DW-1]};
    assign add_sum   = add_sub ? (add_a - add_b) : (add_a + add_b);

    // Operand select for the shared unit
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            pfde_pkg::ST_EXEC:
            begin
                add_a   = {1'b0, rd_reg};
                add_b   = {1'b0, tos_reg};
                add_sub = (sym_reg == pfde_pkg::CH_MINUS);
            end
            pfde_pkg::ST_MUL:
            begin
                add_a = {1'b0, acc_reg};
                add_b = opb_reg[0] ? {1'b0, opa_reg} : '0;
            end
            pfde_pkg::ST_DIV:
            begin
                add_a   = rem_shift;
                add_b   = {1'b0, opb_reg};
                add_sub = 1'b1;
            end
            pfde_pkg::ST_DFIX:
            begin
                add_a   = neg_reg ? '0 : {1'b0, opa_reg};
                add_b   = neg_reg ? {1'b0, opa_reg} : '0;
                add_sub = neg_reg;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        tos_next       = tos_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        acc_next       = acc_reg;
        itr_next       = itr_reg;
        neg_next       = neg_reg;
        mem_we         = 1'b0;
        out_load       = 1'b0;
        last_next_step = last_reg;
        unique case (state_reg)
            pfde_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pfde_pkg::ST_DECODE;
                end
            end
            pfde_pkg::ST_DECODE:
            begin
                state_next = last_next_step ? pfde_pkg::ST_EMIT : pfde_pkg::ST_IDLE;
                priority if (err_reg != pfde_pkg::STS_OK)
                begin
                    // sticky error: ignore the character
                end
                else if (is_digit)
                begin
                    if (count_reg >= CW'(STACK_DEPTH))
                    begin
                        err_next = pfde_pkg::STS_OVERFLOW;
                    end
                    else
                    begin
                        mem_we     = (count_reg != '0);
                        tos_next   = DW'(sym_reg - pfde_pkg::CH_ZERO);
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (!is_op)
                begin
                    err_next = pfde_pkg::STS_BADSYM;
                end
                else if (count_reg < CW'(2))
                begin
                    err_next = pfde_pkg::STS_UNDERFLOW;
                end
                else
                begin
                    // second operand is read from memory this cycle
                    state_next = pfde_pkg::ST_EXEC;
                end
            end
            pfde_pkg::ST_EXEC:
            begin
                state_next = last_next_step ? pfde_pkg::ST_EMIT : pfde_pkg::ST_IDLE;
                priority if (sym_reg == pfde_pkg::CH_STAR)
                begin
                    acc_next   = '0;
                    opa_next   = rd_reg;
                    opb_next   = tos_reg;
                    itr_next   = '0;
                    state_next = pfde_pkg::ST_MUL;
                end
                else if (sym_reg == pfde_pkg::CH_SLASH)
                begin
                    if (tos_reg == '0)
                    begin
                        err_next = pfde_pkg::STS_DIVZERO;
                    end
                    else
                    begin
                        acc_next   = '0;
                        opa_next   = pfde_pkg::mag32(rd_reg);
                        opb_next   = pfde_pkg::mag32(tos_reg);
                        neg_next   = rd_reg[DW-1] ^ tos_reg[DW-1];
                        itr_next   = '0;
                        state_next = pfde_pkg::ST_DIV;
                    end
                end
                else
                begin
                    tos_next   = add_sum[DW-1:0];
                    count_next = cnt_m1;
                end
            end
            pfde_pkg::ST_MUL:
            begin
                // shift-add, one multiplier bit per cycle
                acc_next = add_sum[DW-1:0];
                opa_next = {opa_reg[DW-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[DW-1:1]};
                itr_next = itr_reg + 1'b1;
                if (itr_reg == pfde_pkg::ITER_LAST)
                begin
                    tos_next   = add_sum[DW-1:0];
                    count_next = cnt_m1;
                    state_next = last_next_step ? pfde_pkg::ST_EMIT : pfde_pkg::ST_IDLE;
                end
            end
            pfde_pkg::ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                acc_next = add_sum[DW] ? rem_shift[DW-1:0] : add_sum[DW-1:0];
                opa_next = {opa_reg[DW-2:0], ~add_sum[DW]};
                itr_next = itr_reg + 1'b1;
                if (itr_reg == pfde_pkg::ITER_LAST)
                begin
                    state_next = pfde_pkg::ST_DFIX;
                end
            end
            pfde_pkg::ST_DFIX:
            begin
                tos_next   = add_sum[DW-1:0];
                count_next = cnt_m1;
                state_next = last_next_step ? pfde_pkg::ST_EMIT : pfde_pkg::ST_IDLE;
            end
            pfde_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    count_next = '0;
                    err_next   = pfde_pkg::STS_OK;
                    state_next = pfde_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfde_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfde_pkg::ST_IDLE;
            count_reg     <= '0;
            err_reg       <= pfde_pkg::STS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg  <= symbol;
            last_reg <= last;
        end
        tos_reg <= tos_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        acc_reg <= acc_next;
        itr_reg <= itr_next;
        neg_reg <= neg_next;
        if (out_load)
        begin
            if (err_reg != pfde_pkg::STS_OK)
            begin
                value_reg  <= '0;
                status_reg <= err_reg;
            end
            else if (count_reg == '0)
            begin
                value_reg  <= '0;
                status_reg <= pfde_pkg::STS_EMPTY;
            end
            else
            begin
                value_reg  <= tos_reg;
                status_reg <= pfde_pkg::STS_OK;
            end
        end
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_idx] <= tos_reg;
        end
        if (state_reg == pfde_pkg::ST_DECODE)
        begin
            rd_reg <= stack_mem[rd_idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign status    = status_reg;

    // Checks
    `ASSERT_HOLDS(a_count_range, clk, rst_n, count_reg <= CW'(STACK_DEPTH), "stack count above depth")
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, accept, in_stall, "request not followed by busy")
    `ASSERT_NEXT(a_emit_clears, clk, rst_n, out_load, (count_reg == '0) && (err_reg == pfde_pkg::STS_OK) && out_valid, "result emit did not clear stack")
    `ASSERT_SAME(a_div_nonzero, clk, rst_n, state_reg == pfde_pkg::ST_DIV, opb_reg != '0, "divide with zero divisor")
    `ASSERT_NEXT(a_err_sticky, clk, rst_n, (err_reg != pfde_pkg::STS_OK) && !out_load, err_reg == $past(err_reg), "sticky error changed")

endmodule

`default_nettype wire
